// ----- src/gso_pkg.sv -----
package gso_pkg;

  localparam int DEF_MAX_ROWS = 8;
  localparam int DEF_MAX_COLS = 8;

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int WORD_W    = 32;
  localparam int ACC_W     = 64;
  localparam int DVD_W     = 52;
  localparam int IN_SHIFT  = 12;
  localparam int DVD_SHIFT = 20;
  localparam int SQ_STEPS  = 32;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD,
    S_DOT_RD,
    S_DOT_MUL,
    S_DOT_ACC,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_WR,
    S_NRM_RD,
    S_NRM_MUL,
    S_NRM_ACC,
    S_SQ_GO,
    S_SQRT,
    S_ZERO,
    S_SCL_RD,
    S_SCL_MUL,
    S_SCL_DIV,
    S_SCL_WR,
    S_OUT_RD,
    S_OUT_LAT,
    S_OUT_WAIT
  } state_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [WORD_W-1:0] res;
    if (x > 64'sd2147483647) res = 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) res = 32'sh80000000;
    else res = x[WORD_W-1:0];
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [WORD_W-1:0] x);
    logic signed [OUT_W-1:0] res;
    if (x > 32'sd32767) res = 16'sh7FFF;
    else if (x < -32'sd32768) res = 16'sh8000;
    else res = x[OUT_W-1:0];
    return res;
  endfunction

endpackage

// ----- src/gso_mem.sv -----
module gso_mem #(
  parameter int DEPTH = gso_pkg::DEF_MAX_ROWS * gso_pkg::DEF_MAX_COLS,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [gso_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [gso_pkg::WORD_W-1:0] qa,
  output logic [gso_pkg::WORD_W-1:0] qb
);
  import gso_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

endmodule

// ----- src/gso_isqrt.sv -----
module gso_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gso_pkg::ACC_W-1:0]  radicand,
  output logic                       done,
  output logic [gso_pkg::WORD_W-1:0] root
);
  import gso_pkg::*;

  localparam int CNT_W = $clog2(SQ_STEPS);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [ACC_W-1:0]  src;
  logic [WORD_W+1:0] rem;
  logic [WORD_W+3:0] rem_t;
  logic [WORD_W+3:0] trial;
  logic              fits;

  // one result bit per cycle, two radicand bits brought down
  assign rem_t = {rem, src[ACC_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign fits  = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        root <= '0;
        src  <= radicand;
      end else if (busy) begin
        rem  <= fits ? (WORD_W+2)'(rem_t - trial) : rem_t[WORD_W+1:0];
        root <= {root[WORD_W-2:0], fits};
        src  <= {src[ACC_W-3:0], 2'b00};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(SQ_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/gso_div.sv -----
module gso_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gso_pkg::DVD_W-1:0]  dividend,
  input  logic [gso_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [gso_pkg::DVD_W-1:0]  quotient
);
  import gso_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DVD_W-1:0]  dvd;
  logic [WORD_W-1:0] dsr;
  logic [WORD_W-1:0] rem;
  logic [WORD_W:0]   rem_t;
  logic              fits;

  // restoring division, one quotient bit per cycle
  assign rem_t = {rem, dvd[DVD_W-1]};
  assign fits  = rem_t >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvd      <= dividend;
        dsr      <= divisor;
        quotient <= '0;
      end else if (busy) begin
        rem      <= fits ? WORD_W'(rem_t - {1'b0, dsr}) : rem_t[WORD_W-1:0];
        dvd      <= {dvd[DVD_W-2:0], 1'b0};
        quotient <= {quotient[DVD_W-2:0], fits};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/gram_schmidt_orthonormalizer.sv -----
// load: one word per cycle while idle; the word completing the m x n matrix starts the solve
// solve: per column j, projection onto each earlier column (dot then update), the norm, the root
// and scaling by a serial divide; a zero column is written as zeros instead of root and scaling
// emit: each word is read, registered and held until taken; next load after the last word is taken
// one shared multiplier on a dual-read store; cost set by the serial root and divider
// reset (sync, active high): rows and cols to 8, load count and zero marks cleared, store kept
module gram_schmidt_orthonormalizer #(
  parameter int MAX_ROWS = gso_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gso_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gso_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gso_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [gso_pkg::IN_W-1:0]  element_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [gso_pkg::OUT_W-1:0] element_out,
  output logic                             degenerate,
  output logic                             last_out
);
  import gso_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int COLW  = $clog2(MAX_COLS);

  state_t state, state_next;

  logic [CFG_W-1:0]   rows_reg, cols_reg;
  logic [RCW-1:0]     m_eff;
  logic [CCW-1:0]     n_eff;
  logic [CW-1:0]      total;
  logic [CW-1:0]      load_count;
  logic [MAX_COLS-1:0] marks;

  logic [RCW-1:0] i;
  logic [CCW-1:0] j, k;
  logic [AW-1:0]  row_base;

  logic signed [ACC_W-1:0]  acc, acc_next, prod, prod_c, upd_diff;
  logic signed [WORD_W-1:0] r, aj_hold, dot_r, mul_a, mul_b, sc_val;
  logic signed [WORD_W-1:0] qa, qb;
  logic                     neg;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, addr_a, addr_b;
  logic [WORD_W-1:0] mem_wdata;
  logic [CCW-1:0]    col_a;

  logic              sq_start, sq_done;
  logic [WORD_W-1:0] sq_root;
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_q;
  logic [WORD_W-1:0] mag;

  logic in_acc, last_load, last_row, last_col, k_last, k_meets_j, nrm_phase;
  logic [RCW-1:0] i_nx;
  logic [AW-1:0]  rb_nx;

  always_comb begin
    if (rows_reg == '0) m_eff = RCW'(1);
    else if (int'(rows_reg) > MAX_ROWS) m_eff = RCW'(MAX_ROWS);
    else m_eff = RCW'(rows_reg);
    if (cols_reg == '0) n_eff = CCW'(1);
    else if (int'(cols_reg) > MAX_COLS) n_eff = CCW'(MAX_COLS);
    else n_eff = CCW'(cols_reg);
  end

  assign total     = CW'(CW'(m_eff) * CW'(n_eff));
  assign in_acc    = in_valid && in_ready;
  assign last_load = load_count == total - CW'(1);
  assign last_row  = i == m_eff - RCW'(1);
  assign last_col  = j == n_eff - CCW'(1);
  assign k_last    = k == n_eff - CCW'(1);
  assign k_meets_j = k + CCW'(1) == j;
  assign i_nx      = last_row ? '0 : i + RCW'(1);
  assign rb_nx     = last_row ? '0 : row_base + AW'(n_eff);

  assign nrm_phase = (state == S_NRM_RD) || (state == S_NRM_MUL) || (state == S_NRM_ACC);
  assign col_a     = nrm_phase ? j : k;
  assign addr_a    = row_base + AW'(col_a);
  assign addr_b    = row_base + AW'(j);

  assign mul_a    = (state == S_UPD_MUL) ? r : qa;
  assign mul_b    = (state == S_UPD_MUL) ? qa : qb;
  assign prod_c   = mul_a * mul_b;
  assign acc_next = acc + (prod >>> 8);
  assign dot_r    = sat32(acc_next >>> 16);
  assign upd_diff = ACC_W'(aj_hold) - (prod >>> 24);
  assign mag      = qb[WORD_W-1] ? WORD_W'(~qb + 32'sd1) : WORD_W'(qb);

  // quotient is clamped to 2^31 - 1, or to 2^31 when negative, before the sign goes back on
  always_comb begin
    if (neg) begin
      if (div_q > DVD_W'(64'h8000_0000)) sc_val = 32'sh80000000;
      else sc_val = -$signed(div_q[WORD_W-1:0]);
    end else begin
      if (div_q > DVD_W'(64'h7FFF_FFFF)) sc_val = 32'sh7FFFFFFF;
      else sc_val = $signed(div_q[WORD_W-1:0]);
    end
  end

  gso_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .qa      (qa),
    .qb      (qb)
  );

  gso_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .done     (sq_done),
    .root     (sq_root)
  );

  gso_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag, {DVD_SHIFT{1'b0}}}),
    .divisor  (sq_root),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:     if (in_acc && last_load) state_next = S_NRM_RD;
      S_DOT_RD:   state_next = S_DOT_MUL;
      S_DOT_MUL:  state_next = S_DOT_ACC;
      S_DOT_ACC:  state_next = last_row ? S_UPD_RD : S_DOT_RD;
      S_UPD_RD:   state_next = S_UPD_MUL;
      S_UPD_MUL:  state_next = S_UPD_WR;
      S_UPD_WR: begin
        if (!last_row) state_next = S_UPD_RD;
        else if (k_meets_j) state_next = S_NRM_RD;
        else state_next = S_DOT_RD;
      end
      S_NRM_RD:   state_next = S_NRM_MUL;
      S_NRM_MUL:  state_next = S_NRM_ACC;
      S_NRM_ACC:  state_next = last_row ? S_SQ_GO : S_NRM_RD;
      S_SQ_GO:    state_next = (acc == '0) ? S_ZERO : S_SQRT;
      S_SQRT:     if (sq_done) state_next = S_SCL_RD;
      S_ZERO: begin
        if (last_row) state_next = last_col ? S_OUT_RD : S_DOT_RD;
      end
      S_SCL_RD:   state_next = S_SCL_MUL;
      S_SCL_MUL:  state_next = S_SCL_DIV;
      S_SCL_DIV:  if (div_done) state_next = S_SCL_WR;
      S_SCL_WR: begin
        if (!last_row) state_next = S_SCL_RD;
        else state_next = last_col ? S_OUT_RD : S_DOT_RD;
      end
      S_OUT_RD:   state_next = S_OUT_LAT;
      S_OUT_LAT:  state_next = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (out_ready) state_next = last_out ? S_LOAD : S_OUT_RD;
      end
      default:    state_next = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = state == S_LOAD;
    sq_start  = (state == S_SQ_GO) && (acc != '0);
    div_start = state == S_SCL_MUL;
    mem_we    = 1'b0;
    mem_waddr = addr_b;
    mem_wdata = '0;
    unique case (state)
      S_LOAD: begin
        mem_we    = in_acc;
        mem_waddr = load_count[AW-1:0];
        mem_wdata = WORD_W'({{(WORD_W-IN_W-IN_SHIFT){element_in[IN_W-1]}},
                             element_in, {IN_SHIFT{1'b0}}});
      end
      S_UPD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = sat32(upd_diff);
      end
      S_ZERO: begin
        mem_we = 1'b1;
      end
      S_SCL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = sc_val;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      rows_reg   <= DIM_RESET;
      cols_reg   <= DIM_RESET;
      load_count <= '0;
      marks      <= '0;
      out_valid  <= 1'b0;
      i          <= '0;
      j          <= '0;
      k          <= '0;
      row_base   <= '0;
      acc        <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            load_count <= last_load ? '0 : load_count + CW'(1);
            i        <= '0;
            j        <= '0;
            k        <= '0;
            row_base <= '0;
            acc      <= '0;
          end
        end
        S_DOT_MUL, S_NRM_MUL: prod <= prod_c;
        S_DOT_ACC: begin
          i        <= i_nx;
          row_base <= rb_nx;
          if (last_row) begin
            r   <= dot_r;
            acc <= '0;
          end else begin
            acc <= acc_next;
          end
        end
        S_UPD_MUL: begin
          prod    <= prod_c;
          aj_hold <= qb;
        end
        S_UPD_WR: begin
          i        <= i_nx;
          row_base <= rb_nx;
          if (last_row) k <= k + CCW'(1);
        end
        S_NRM_ACC: begin
          acc      <= acc_next;
          i        <= i_nx;
          row_base <= rb_nx;
        end
        // root unit latches the sum at the same edge that clears it here
        S_SQ_GO: acc <= '0;
        S_ZERO, S_SCL_WR: begin
          if (state == S_ZERO) marks[j[COLW-1:0]] <= 1'b1;
          i        <= i_nx;
          row_base <= rb_nx;
          if (last_row) begin
            k <= '0;
            if (!last_col) j <= j + CCW'(1);
          end
        end
        S_SCL_MUL: neg <= qb[WORD_W-1];
        S_OUT_LAT: begin
          out_valid   <= 1'b1;
          element_out <= sat16(qa >>> 10);
          degenerate  <= marks[k[COLW-1:0]];
          last_out    <= last_row && k_last;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_out) begin
              marks    <= '0;
              i        <= '0;
              k        <= '0;
              row_base <= '0;
            end else if (k_last) begin
              k        <= '0;
              i        <= i_nx;
              row_base <= rb_nx;
            end else begin
              k <= k + CCW'(1);
            end
          end
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: rows_reg <= cfg_data;
          REG_COLS: cols_reg <= cfg_data;
          default:  rows_reg <= rows_reg;
        endcase
        load_count <= '0;
        marks      <= '0;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("output word pending while loading");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> sq_root != '0)
    else $error("scaling started with zero root");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_out) |=> in_ready)
    else $error("not back to loading after last word");

endmodule
